// ----- sv/scale2x_pixel_upscaler_core_defines.svh -----
// Assertion macros shared by the Scale2x upscaler RTL.
`ifndef SCALE2X_PIXEL_UPSCALER_CORE_DEFINES_SVH
`define SCALE2X_PIXEL_UPSCALER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define SCL2X_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scale2x core check failed");
// Next-cycle implication, disabled while reset is asserted
`define SCL2X_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scale2x core check failed");
`else
`define SCL2X_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define SCL2X_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/scl2x_pkg.sv -----
// Shared types and constants of the Scale2x upscaler.
package scl2x_pkg;

    localparam int PIX_W        = 32;
    localparam int OUT_X_W      = 11;
    localparam int OUT_Y_W      = 13;
    localparam int ROW_W        = 12;
    localparam int IMG_W_W      = 11;
    localparam int IMG_H_W      = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int IMG_W_RESET  = 256;
    localparam int IMG_H_RESET  = 256;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int NUM_BLK      = 3;
    localparam int CNT_W        = 2;
    localparam int OUT_DATA_W   = 56;

    // Quadrant of a 2x2 block: bit 0 is the column, bit 1 the row
    localparam logic [1:0] QUAD_FIRST = 2'd0;
    localparam logic [1:0] QUAD_LAST  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [3:0] quad_t;

    // One destination block: four pixels and the even base coordinates
    typedef struct packed {
        quad_t              pix;
        logic [OUT_X_W-1:0] bx;
        logic [OUT_Y_W-1:0] by;
    } blk_t;

    // Blocks caused by one item, in emission order where valid
    typedef struct packed {
        logic [NUM_BLK-1:0] vld;
        blk_t [NUM_BLK-1:0] blk;
    } blk_set_t;

endpackage

// ----- sv/scl2x_row_ram.sv -----
// Row store: one write port and two registered read ports.
module scl2x_row_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        wr_addr,
    input  scl2x_pkg::pix_t      wr_data,
    input  logic                 re,
    input  logic [AW-1:0]        rd_addr_a,
    input  logic [AW-1:0]        rd_addr_b,
    output scl2x_pkg::pix_t      rd_data_a,
    output scl2x_pkg::pix_t      rd_data_b
);

    scl2x_pkg::pix_t mem [DEPTH];

    // Read old contents, then write
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ----- sv/scl2x_rule.sv -----
// Scale2x rule for one 2x2 block from the centre pixel and its four neighbors.
module scl2x_rule (
    input  scl2x_pkg::pix_t  up,
    input  scl2x_pkg::pix_t  left,
    input  scl2x_pkg::pix_t  centre,
    input  scl2x_pkg::pix_t  right,
    input  scl2x_pkg::pix_t  down,
    output scl2x_pkg::quad_t quad
);

    logic active;

    // Apply the corner rule only where the cross is not symmetric
    always_comb begin
        active  = (up != down) && (left != right);
        quad[0] = (active && (left == up))    ? left  : centre;
        quad[1] = (active && (up == right))   ? right : centre;
        quad[2] = (active && (left == down))  ? left  : centre;
        quad[3] = (active && (down == right)) ? right : centre;
    end

endmodule

// ----- sv/scl2x_emit.sv -----
// Result sequencer: holds the blocks of one item and sends one pixel per cycle while m_tready allows.
`include "scale2x_pixel_upscaler_core_defines.svh"

module scl2x_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  scl2x_pkg::blk_set_t                 in_set,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [scl2x_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);

    localparam int NB = scl2x_pkg::NUM_BLK;
    localparam int CN = scl2x_pkg::CNT_W;
    localparam int XW = scl2x_pkg::OUT_X_W;
    localparam int YW = scl2x_pkg::OUT_Y_W;

    scl2x_pkg::blk_t [NB-1:0] slot_reg, slot_next, comp;
    logic [CN-1:0]            cnt_reg, cnt_next, comp_cnt;
    logic [1:0]               sub_reg, sub_next;
    logic                     m_valid_reg, m_valid_next;
    logic [XW-1:0]            m_x_reg;
    logic [YW-1:0]            m_y_reg;
    scl2x_pkg::pix_t          m_pix_reg;
    logic                     m_last_reg;
    logic                     out_free, take, fin, load;

    // Pack the valid blocks to the front
    always_comb begin
        comp     = '0;
        comp_cnt = '0;
        for (int i = 0; i < NB; i++) begin
            if (in_set.vld[i]) begin
                comp[comp_cnt] = in_set.blk[i];
                comp_cnt       = comp_cnt + CN'(1);
            end
        end
    end

    // Advance through quadrants and blocks
    always_comb begin
        out_free  = !m_valid_reg || m_tready;
        take      = (cnt_reg != '0) && out_free;
        fin       = take && (sub_reg == scl2x_pkg::QUAD_LAST) && (cnt_reg == CN'(1));
        in_ready  = (cnt_reg == '0) || fin;
        load      = in_valid && in_ready;
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        sub_next  = sub_reg;
        if (load) begin
            slot_next = comp;
            cnt_next  = comp_cnt;
            sub_next  = scl2x_pkg::QUAD_FIRST;
        end else if (take) begin
            if (sub_reg == scl2x_pkg::QUAD_LAST) begin
                for (int i = 0; i < NB - 1; i++) begin
                    slot_next[i] = slot_reg[i+1];
                end
                cnt_next = cnt_reg - CN'(1);
                sub_next = scl2x_pkg::QUAD_FIRST;
            end else begin
                sub_next = sub_reg + 2'd1;
            end
        end
        m_valid_next = take ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            sub_reg     <= scl2x_pkg::QUAD_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            sub_reg     <= sub_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold block payload and load the output register
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (take) begin
            m_pix_reg  <= slot_reg[0].pix[sub_reg];
            m_x_reg    <= slot_reg[0].bx | XW'(sub_reg[0]);
            m_y_reg    <= slot_reg[0].by | YW'(sub_reg[1]);
            m_last_reg <= fin;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;

    `SCL2X_ASSERT_IMPL(a_sub_idle, aclk, aresetn, cnt_reg == '0, sub_reg == scl2x_pkg::QUAD_FIRST)
    `SCL2X_ASSERT_IMPL(a_last_odd, aclk, aresetn, m_valid_reg && m_last_reg, m_x_reg[0] && m_y_reg[0])
    `SCL2X_ASSERT_NEXT(a_stall_hold, aclk, aresetn, (cnt_reg != '0) && !out_free, $stable(cnt_reg) && $stable(sub_reg))

endmodule

// ----- sv/scale2x_pixel_upscaler_core.sv -----
// Scale2x upscaler top level: frame counters, row stores, input stage and result sequencer.
// Source pixels enter in raster order on s_; each yields a 2x2 destination block by the
// Scale2x rule, sent on m_ one pixel per cycle unless m_tready stalls it. A block goes out
// once the pixel below it has arrived: rows above the last give four results per item while
// the next row streams in, and on the last row each item after the first also gives the block
// of the column before it, with the block of the final column added at the row's last pixel;
// m_tlast marks the last result of an item. An item on the first row of a frame taller than
// one row gives no results; items give four results on the middle rows, up to eight on the
// last row and twelve at the last pixel of a frame. From input accept to first result, an item
// passes the input stage, where the row stores give registered reads, and the output register.
// Each row store is MAX_WIDTH x 32 bits with one write and two reads per cycle; the two swap
// roles at each row end and need no clearing after reset. Writing either configuration
// register restarts the frame at row zero, column zero.
`include "scale2x_pixel_upscaler_core_defines.svh"

module scale2x_pixel_upscaler_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [31:0] pixel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [scl2x_pkg::PIX_W-1:0]          s_tdata,
    // m_tdata: [10:0] out_x, [23:11] out_y, [55:24] out_pixel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scl2x_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [scl2x_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scl2x_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > scl2x_pkg::IMG_W_W) ? CW + 1 : scl2x_pkg::IMG_W_W;
    localparam int RW = scl2x_pkg::ROW_W;
    localparam int HW = scl2x_pkg::IMG_H_W;
    localparam int XW = scl2x_pkg::OUT_X_W;
    localparam int YW = scl2x_pkg::OUT_Y_W;

    logic [scl2x_pkg::IMG_W_W-1:0] img_w_reg;
    logic [HW-1:0]                 img_h_reg;
    logic [CW-1:0]                 col_reg, col_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic                          wr_bank_reg, wr_bank_next;
    scl2x_pkg::pix_t               held_left_reg, held_cur_reg;

    logic                          s1_valid_reg, s1_valid_next;
    scl2x_pkg::pix_t               s1_pix_reg, s1_left_reg, s1_cur_reg;
    logic [CW-1:0]                 s1_x_reg;
    logic [RW-1:0]                 s1_r_reg;
    logic                          s1_last_row_reg, s1_row_end_reg, s1_bank_reg;
    scl2x_pkg::pix_t               last_nc_reg;

    logic [WW-1:0]                 w_raw, w_nz, w_eff;
    logic [CW-1:0]                 w_last;
    logic [HW-1:0]                 h_nz, h_eff;
    logic [RW-1:0]                 h_last;
    logic                          row_end, last_row;
    logic                          s_acc, cfg_acc, cfg_hit;
    logic [CW-1:0]                 addr_b;
    scl2x_pkg::pix_t               rd_a0, rd_b0, rd_a1, rd_b1;
    scl2x_pkg::pix_t               nc, nr, up_old;
    logic                          x0, x1, r0, r1;
    logic [CW-1:0]                 x_m1;
    logic [RW-1:0]                 r_m1;
    scl2x_pkg::pix_t               a_up, a_left, b_up, b_left, c_up, c_left;
    scl2x_pkg::quad_t              quad_a, quad_b, quad_c;
    scl2x_pkg::blk_set_t           set;
    logic                          emit_ready;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_tready  = !s1_valid_reg || emit_ready;
    assign s_acc     = s_tvalid && s_tready;

    // Decode the register index of a write
    always_comb begin
        case (scl2x_pkg::cfg_idx_t'(cfg_index))
            scl2x_pkg::CFG_IMAGE_WIDTH:  cfg_hit = cfg_acc;
            scl2x_pkg::CFG_IMAGE_HEIGHT: cfg_hit = cfg_acc;
            default:                     cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= scl2x_pkg::IMG_W_W'(scl2x_pkg::IMG_W_RESET);
            img_h_reg <= HW'(scl2x_pkg::IMG_H_RESET);
        end else if (cfg_acc) begin
            case (scl2x_pkg::cfg_idx_t'(cfg_index))
                scl2x_pkg::CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data[scl2x_pkg::IMG_W_W-1:0];
                scl2x_pkg::CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the frame size: zero acts as one, saturate at the store depth and height limit
    always_comb begin
        w_raw  = WW'(img_w_reg);
        w_nz   = (w_raw == '0) ? WW'(1) : w_raw;
        w_eff  = (w_nz > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_nz;
        w_last = CW'(w_eff - WW'(1));
        h_nz   = (img_h_reg == '0) ? HW'(1) : img_h_reg;
        h_eff  = (h_nz > HW'(scl2x_pkg::HEIGHT_LIMIT)) ? HW'(scl2x_pkg::HEIGHT_LIMIT) : h_nz;
        h_last = RW'(h_eff - HW'(1));
        row_end  = (col_reg == w_last);
        last_row = (row_reg == h_last);
        addr_b   = row_end ? col_reg : col_reg + CW'(1);
    end

    // Advance column, row and store bank; a register write restarts the frame
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        wr_bank_next = wr_bank_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (s_acc) begin
            if (row_end) begin
                col_next     = '0;
                row_next     = last_row ? '0 : row_reg + RW'(1);
                wr_bank_next = ~wr_bank_reg;
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
        s1_valid_next = s_acc ? 1'b1 : (emit_ready ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            wr_bank_reg   <= 1'b0;
            held_left_reg <= '0;
            held_cur_reg  <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            wr_bank_reg  <= wr_bank_next;
            s1_valid_reg <= s1_valid_next;
            if (s_acc) begin
                held_left_reg <= held_cur_reg;
                held_cur_reg  <= s_tdata;
            end
        end
    end

    // Capture the item and its position into the input stage
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pix_reg      <= s_tdata;
            s1_x_reg        <= col_reg;
            s1_r_reg        <= row_reg;
            s1_last_row_reg <= last_row;
            s1_row_end_reg  <= row_end;
            s1_bank_reg     <= wr_bank_reg;
            s1_left_reg     <= held_left_reg;
            s1_cur_reg      <= held_cur_reg;
        end
        if (s1_valid_reg && emit_ready) begin
            last_nc_reg <= nc;
        end
    end

    scl2x_row_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_bank0 (
        .aclk      (aclk),
        .we        (s_acc && !wr_bank_reg),
        .wr_addr   (col_reg),
        .wr_data   (s_tdata),
        .re        (s_acc),
        .rd_addr_a (col_reg),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a0),
        .rd_data_b (rd_b0)
    );

    scl2x_row_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_bank1 (
        .aclk      (aclk),
        .we        (s_acc && wr_bank_reg),
        .wr_addr   (col_reg),
        .wr_data   (s_tdata),
        .re        (s_acc),
        .rd_addr_a (col_reg),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a1),
        .rd_data_b (rd_b1)
    );

    // Pick neighbors: the bank being written holds the row two above
    always_comb begin
        up_old = s1_bank_reg ? rd_a1 : rd_a0;
        nc     = s1_bank_reg ? rd_a0 : rd_a1;
        nr     = s1_bank_reg ? rd_b0 : rd_b1;
        x0     = (s1_x_reg == '0);
        x1     = (s1_x_reg == CW'(1));
        r0     = (s1_r_reg == '0);
        r1     = (s1_r_reg == RW'(1));
        x_m1   = s1_x_reg - CW'(1);
        r_m1   = s1_r_reg - RW'(1);
        a_up   = r1 ? nc : up_old;
        a_left = x0 ? nc : last_nc_reg;
        b_up   = r0 ? s1_cur_reg : last_nc_reg;
        b_left = x1 ? s1_cur_reg : s1_left_reg;
        c_up   = r0 ? s1_pix_reg : nc;
        c_left = x0 ? s1_pix_reg : s1_cur_reg;
    end

    // Block of the row above
    scl2x_rule u_rule_above (
        .up     (a_up),
        .left   (a_left),
        .centre (nc),
        .right  (nr),
        .down   (s1_pix_reg),
        .quad   (quad_a)
    );

    // Last row: block of the previous column
    scl2x_rule u_rule_prev (
        .up     (b_up),
        .left   (b_left),
        .centre (s1_cur_reg),
        .right  (s1_pix_reg),
        .down   (s1_cur_reg),
        .quad   (quad_b)
    );

    // Last row: block of the final column
    scl2x_rule u_rule_final (
        .up     (c_up),
        .left   (c_left),
        .centre (s1_pix_reg),
        .right  (s1_pix_reg),
        .down   (s1_pix_reg),
        .quad   (quad_c)
    );

    always_comb begin
        set.vld[0]     = !r0;
        set.vld[1]     = s1_last_row_reg && !x0;
        set.vld[2]     = s1_last_row_reg && s1_row_end_reg;
        set.blk[0].pix = quad_a;
        set.blk[1].pix = quad_b;
        set.blk[2].pix = quad_c;
        set.blk[0].bx  = XW'({s1_x_reg, 1'b0});
        set.blk[0].by  = YW'({r_m1, 1'b0});
        set.blk[1].bx  = XW'({x_m1, 1'b0});
        set.blk[1].by  = YW'({s1_r_reg, 1'b0});
        set.blk[2].bx  = XW'({s1_x_reg, 1'b0});
        set.blk[2].by  = YW'({s1_r_reg, 1'b0});
    end

    scl2x_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg),
        .in_ready (emit_ready),
        .in_set   (set),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `SCL2X_ASSERT_IMPL(a_col_range, aclk, aresetn, 1'b1, col_reg <= w_last)
    `SCL2X_ASSERT_IMPL(a_row_range, aclk, aresetn, 1'b1, row_reg <= h_last)
    `SCL2X_ASSERT_NEXT(a_bank_hold, aclk, aresetn, !(s_acc && row_end), $stable(wr_bank_reg))

endmodule

// ----- tb/scale2x_pixel_upscaler_core_test.sv -----
// Self-checking testbench for the Scale2x upscaler core: predicts every 2x2 block and checks it.
module scale2x_pixel_upscaler_core_test;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_ITEMS = 340;
    localparam int WIDE_ITEMS = 48;
    localparam int ROW_SLOTS = 1024;
    localparam bit [31:0] INK = 32'h0000_0000;
    localparam bit [31:0] PAPER = 32'hFFFF_FFFF;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_style_t;

    // One destination pixel as it should leave the block
    typedef struct {
        bit [10:0] x;
        bit [12:0] y;
        bit [31:0] pix;
        bit        last;
    } dest_px_t;

    class upscale_scoreboard;
        dest_px_t  due_pixels[$];
        bit [31:0] row_store[2][ROW_SLOTS];
        bit        newer_sel;
        int unsigned col_at;
        int unsigned row_at;
        bit [31:0] held_left;
        bit [31:0] held_cur;
        bit [10:0] width_reg = 11'd256;
        bit [12:0] height_reg = 13'd256;
        int errors;
        int sources;
        int checked;

        // A write to either register restarts the frame; stores and held pixels stay
        function void set_register(scl2x_pkg::cfg_idx_t idx, bit [12:0] v);
            if (idx == scl2x_pkg::CFG_IMAGE_WIDTH) begin
                width_reg = v[10:0];
            end else if (idx == scl2x_pkg::CFG_IMAGE_HEIGHT) begin
                height_reg = v;
            end else begin
                return;
            end
            col_at = 0;
            row_at = 0;
        endfunction

        // Queue the four pixels of one block by the Scale2x rule
        function void add_block(int unsigned bx, int unsigned by,
                                bit [31:0] b, bit [31:0] d, bit [31:0] e,
                                bit [31:0] f, bit [31:0] h);
            bit [31:0] q[4];
            dest_px_t px;
            for (int k = 0; k < 4; k++) q[k] = e;
            if (b != h && d != f) begin
                if (d == b) q[0] = d;
                if (b == f) q[1] = f;
                if (d == h) q[2] = d;
                if (h == f) q[3] = f;
            end
            for (int k = 0; k < 4; k++) begin
                px.x = 11'(2 * bx + k % 2);
                px.y = 13'(2 * by + k / 2);
                px.pix = q[k];
                px.last = 1'b0;
                due_pixels.push_back(px);
            end
        endfunction

        function void note_source(bit [31:0] p);
            int unsigned w, h, x, r, base;
            bit [31:0] up, lf, rt, e;
            bit older_sel;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > ROW_SLOTS) w = ROW_SLOTS;
            h = height_reg;
            if (h == 0) h = 1;
            if (h > scl2x_pkg::HEIGHT_LIMIT) h = scl2x_pkg::HEIGHT_LIMIT;
            x = (col_at >= w) ? w - 1 : col_at;
            r = (row_at >= h) ? h - 1 : row_at;
            older_sel = !newer_sel;
            base = due_pixels.size();
            sources++;

            // Block of the row above, now that its lower neighbour is here
            if (r >= 1) begin
                up = (r == 1) ? row_store[newer_sel][x] : row_store[older_sel][x];
                lf = row_store[newer_sel][(x == 0) ? 0 : x - 1];
                rt = row_store[newer_sel][(x + 1 >= w) ? x : x + 1];
                add_block(x, r - 1, up, lf, row_store[newer_sel][x], rt, p);
            end

            // Last row runs one column behind and flushes at row end
            if (r == h - 1) begin
                if (x >= 1) begin
                    e = held_cur;
                    lf = (x == 1) ? e : held_left;
                    up = (r == 0) ? e : row_store[newer_sel][x - 1];
                    add_block(x - 1, r, up, lf, e, p, e);
                end
                if (x == w - 1) begin
                    lf = (x == 0) ? p : held_cur;
                    up = (r == 0) ? p : row_store[newer_sel][x];
                    add_block(x, r, up, lf, p, p, p);
                end
            end

            row_store[older_sel][x] = p;
            held_left = held_cur;
            held_cur = p;

            // Advance the counters; the stores swap roles at row end
            if (x == w - 1) begin
                newer_sel = older_sel;
                col_at = 0;
                row_at = (r == h - 1) ? 0 : r + 1;
            end else begin
                col_at = x + 1;
                row_at = r;
            end
            if (due_pixels.size() > base) due_pixels[due_pixels.size() - 1].last = 1'b1;
        endfunction

        function void check_result(bit [10:0] x, bit [12:0] y, bit [31:0] pix, bit last);
            dest_px_t want;
            if (due_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: x=%0d y=%0d pixel=%08h last=%0b",
                         $time, x, y, pix, last);
                return;
            end
            want = due_pixels.pop_front();
            checked++;
            if (want.x != x || want.y != y || want.pix != pix || want.last != last) begin
                errors++;
                $display("%0t: mismatch: expected x=%0d y=%0d pixel=%08h last=%0b",
                         $time, want.x, want.y, want.pix, want.last);
                $display("%0t:           actual x=%0d y=%0d pixel=%08h last=%0b",
                         $time, x, y, pix, last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [scl2x_pkg::OUT_DATA_W-1:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [scl2x_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [scl2x_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    upscale_scoreboard board;
    rx_style_t rx_style = RX_ALWAYS;
    int        hold_asked = 0;
    int        hold_done = 0;
    int        hold_left = 0;
    int unsigned rx_tick = 0;
    int        quiet = 0;
    bit        sender_gaps;
    int        burst_left;
    bit [31:0] palette[4];
    int        palette_size;
    int        shapes;

    scale2x_pixel_upscaler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watch all three channels; results are checked before the same edge's item is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[10:0], m_tdata[23:11], m_tdata[55:24], m_tlast);
            if (s_tvalid && s_tready) board.note_source(s_tdata);
            if (cfg_valid && cfg_ready)
                board.set_register(scl2x_pkg::cfg_idx_t'(cfg_index), cfg_data);
        end
    end

    // Result side: long hold on request, otherwise the current stall style
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done <= hold_asked;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_tready <= (rx_tick % 7 != 3) && (rx_tick % 5 != 1);
                default: m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // End the run if nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, board.due_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one pixel, opening a random gap between bursts when sender gaps are enabled
    task automatic send_pixel(input bit [31:0] p);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= p;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic feed_pixels(input int count);
        bit [31:0] p;
        for (int i = 0; i < count; i++) begin
            if (palette_size == 0 || $urandom_range(0, 15) == 0) p = $urandom;
            else p = palette[$urandom_range(0, palette_size - 1)];
            send_pixel(p);
        end
    endtask

    // Stop sending, wait for every expected result, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (board.due_pixels.size() != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Write both registers back to back; each write restarts the frame
    task automatic configure(input bit [12:0] wv, input bit [12:0] hv);
        cfg_valid <= 1'b1;
        cfg_index <= scl2x_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= wv;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= scl2x_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= hv;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shapes++;
    endtask

    task automatic new_palette();
        palette_size = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(2, 4);
        for (int i = 0; i < 4; i++) palette[i] = $urandom;
    endtask

    initial begin
        int w, h, n, random_items;
        board = new;
        random_items = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset shape is 256x256: the first row yields nothing
        sender_gaps = 1'b0;
        send_pixel(INK);
        send_pixel(PAPER);
        send_pixel(32'h1234_5678);
        settle();

        // Zero width and height act as a 1x1 image
        configure(13'd0, 13'd0);
        send_pixel(PAPER);
        send_pixel(INK);
        settle();

        // 3x3 diagonal edge, where the rule picks neighbours
        configure(13'd3, 13'd3);
        send_pixel(INK); send_pixel(PAPER); send_pixel(PAPER);
        send_pixel(INK); send_pixel(INK); send_pixel(PAPER);
        send_pixel(PAPER); send_pixel(INK); send_pixel(INK);
        settle();

        configure(13'd2, 13'd2);
        send_pixel(32'hA5A5_5A5A);
        send_pixel(32'h5A5A_A5A5);
        send_pixel(PAPER);
        send_pixel(INK);
        settle();

        // Single row image: the last-row path only
        configure(13'd4, 13'd1);
        send_pixel(INK);
        send_pixel(PAPER);
        send_pixel(PAPER);
        send_pixel(32'h8000_0001);
        settle();

        // Hold the result side off while the sender keeps pushing
        configure(13'd8, 13'd12);
        new_palette();
        rx_style <= RX_ALWAYS;
        hold_asked <= hold_asked + 1;
        feed_pixels(96);
        random_items += 96;
        settle();

        // Random shapes, mostly whole frames, some cut short by a register write
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w = 1;
                1: w = $urandom_range(20, 32);
                default: w = $urandom_range(2, 9);
            endcase
            h = $urandom_range(1, 6);
            configure(13'(w) | 13'($urandom_range(0, 3) << 11), 13'(h));
            rx_style <= rx_style_t'($urandom_range(0, 3));
            sender_gaps = ($urandom_range(0, 2) != 0);
            new_palette();
            n = (w > 9) ? w * h : w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, w * h);
            feed_pixels(n);
            random_items += n;
            settle();
        end

        // Width field all ones saturates at the row store size; run part of that row
        configure(13'h1FFF, 13'd1);
        rx_style <= RX_RANDOM;
        sender_gaps = 1'b1;
        new_palette();
        feed_pixels(WIDE_ITEMS);
        settle();

        // Height field all ones saturates; feed a narrow column for a while
        configure(13'd1, 13'h1FFF);
        rx_style <= RX_PATTERN;
        feed_pixels(12);
        settle();

        $display("Fed %0d source pixels over %0d image shapes, from 1x1 to saturated sizes",
                 board.sources, shapes);
        $display("Checked %0d destination pixels, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
